### rtl/cell_fault_monitor_core_defines.svh
// Assertion helpers for the cell fault monitor.
`ifndef CELL_FAULT_MONITOR_CORE_DEFINES_SVH
`define CELL_FAULT_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cfm_pkg.sv
package cfm_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FAULT_W   = 3;
  localparam int unsigned WARN_W    = 4;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_VOLT_WARN  = 3'd0,
    REG_HIGH_VOLT_FAULT = 3'd1,
    REG_LOW_VOLT_WARN   = 3'd2,
    REG_LOW_VOLT_FAULT  = 3'd3,
    REG_IMBALANCE_WARN  = 3'd4,
    REG_HIGH_TEMP_WARN  = 3'd5,
    REG_HIGH_TEMP_FAULT = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    KIND_VOLT = 1'b0,
    KIND_TEMP = 1'b1
  } kind_t;

  // Release hysteresis around the fault thresholds.
  localparam sample_t HIGH_VOLT_MARGIN = 16'd500;
  localparam sample_t LOW_VOLT_MARGIN  = 16'd500;
  localparam sample_t HIGH_TEMP_MARGIN = 16'd500;

  // A fault sets once the pass counter has gone beyond this value.
  localparam logic [1:0] DEBOUNCE_LIMIT = 2'd2;

  localparam int unsigned FAULT_HV = 0;
  localparam int unsigned FAULT_LV = 1;
  localparam int unsigned FAULT_HT = 2;

  localparam int unsigned WARN_HV  = 0;
  localparam int unsigned WARN_LV  = 1;
  localparam int unsigned WARN_IMB = 2;
  localparam int unsigned WARN_HT  = 3;

  localparam sample_t SAMPLE_MAX = 16'hFFFF;
  localparam sample_t SAMPLE_MIN = 16'h0000;

  typedef struct packed {
    sample_t high_volt_warn;
    sample_t high_volt_fault;
    sample_t low_volt_warn;
    sample_t low_volt_fault;
    sample_t imbalance_warn;
    sample_t high_temp_warn;
    sample_t high_temp_fault;
  } thresholds_t;

  typedef struct packed {
    logic    valid;
    kind_t   kind;
    sample_t value;
    logic    last;
  } stage_item_t;

  typedef struct packed {
    kind_t               kind;
    sample_t             highest;
    sample_t             lowest;
    sample_t             spread;
    logic [FAULT_W-1:0]  fault_flags;
    logic [WARN_W-1:0]   warning_flags;
    logic                fault_line;
  } result_t;

endpackage

### rtl/cfm_sample_if.sv
interface cfm_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [cfm_pkg::SAMPLE_W-1:0]  sample_value;
  logic                          last_sample;

  modport source (output valid, output cmd, output sample_value, output last_sample,
                  input ready);
  modport sink   (input valid, input cmd, input sample_value, input last_sample,
                  output ready);
endinterface

### rtl/cfm_result_if.sv
interface cfm_result_if;
  logic                          valid;
  logic                          ready;
  logic                          channel_kind;
  logic [cfm_pkg::SAMPLE_W-1:0]  highest;
  logic [cfm_pkg::SAMPLE_W-1:0]  lowest;
  logic [cfm_pkg::SAMPLE_W-1:0]  spread;
  logic [cfm_pkg::FAULT_W-1:0]   fault_flags_out;
  logic [cfm_pkg::WARN_W-1:0]    warning_flags_out;
  logic                          fault_line_out;

  modport source (output valid, output channel_kind, output highest, output lowest,
                  output spread, output fault_flags_out, output warning_flags_out,
                  output fault_line_out, input ready);
  modport sink   (input valid, input channel_kind, input highest, input lowest,
                  input spread, input fault_flags_out, input warning_flags_out,
                  input fault_line_out, output ready);
endinterface

### rtl/cfm_cfg_if.sv
interface cfm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cfm_pkg::CFG_IDX_W-1:0] index;
  logic [cfm_pkg::SAMPLE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cfm_cfg_regs.sv
module cfm_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  cfm_cfg_if.sink              cfg,
  output cfm_pkg::thresholds_t thr
);

  cfm_pkg::thresholds_t regs;

  assign cfg.ready = 1'b1;
  assign thr       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.high_volt_warn  <= cfm_pkg::SAMPLE_MAX;
      regs.high_volt_fault <= cfm_pkg::SAMPLE_MAX;
      regs.low_volt_warn   <= cfm_pkg::SAMPLE_MIN;
      regs.low_volt_fault  <= cfm_pkg::SAMPLE_MIN;
      regs.imbalance_warn  <= cfm_pkg::SAMPLE_MAX;
      regs.high_temp_warn  <= cfm_pkg::SAMPLE_MAX;
      regs.high_temp_fault <= cfm_pkg::SAMPLE_MAX;
    end else if (cfg.valid && cfg.ready) begin
      case (cfm_pkg::cfg_reg_t'(cfg.index))
        cfm_pkg::REG_HIGH_VOLT_WARN:  regs.high_volt_warn  <= cfg.data;
        cfm_pkg::REG_HIGH_VOLT_FAULT: regs.high_volt_fault <= cfg.data;
        cfm_pkg::REG_LOW_VOLT_WARN:   regs.low_volt_warn   <= cfg.data;
        cfm_pkg::REG_LOW_VOLT_FAULT:  regs.low_volt_fault  <= cfg.data;
        cfm_pkg::REG_IMBALANCE_WARN:  regs.imbalance_warn  <= cfg.data;
        cfm_pkg::REG_HIGH_TEMP_WARN:  regs.high_temp_warn  <= cfg.data;
        cfm_pkg::REG_HIGH_TEMP_FAULT: regs.high_temp_fault <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/cfm_in_stage.sv
module cfm_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  cfm_sample_if.sink           samples,
  input  logic                 advance,
  output cfm_pkg::stage_item_t item
);

  logic             item_valid;
  cfm_pkg::kind_t   item_kind;
  cfm_pkg::sample_t item_value;
  logic             item_last;

  // The register frees up in the same cycle the evaluation stage consumes it.
  assign samples.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (samples.ready) begin
      item_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      item_kind  <= cfm_pkg::kind_t'(samples.cmd);
      item_value <= samples.sample_value;
      item_last  <= samples.last_sample;
    end
  end

  assign item.valid = item_valid;
  assign item.kind  = item_kind;
  assign item.value = item_value;
  assign item.last  = item_last;

endmodule

### rtl/cfm_eval.sv
module cfm_eval (
  input  logic                 clk,
  input  logic                 rst,
  input  cfm_pkg::thresholds_t thr,
  input  cfm_pkg::stage_item_t item,
  output logic                 advance,
  cfm_result_if.source         results
);

  cfm_pkg::sample_t volt_max, volt_min, temp_max, temp_min;
  logic             volt_batch_open, temp_batch_open;
  logic [1:0]       high_volt_count, low_volt_count, high_temp_count;
  logic             high_volt_latched;
  logic [cfm_pkg::FAULT_W-1:0] fault_flags;
  logic [cfm_pkg::WARN_W-1:0]  warning_flags;
  logic             fault_line;

  cfm_pkg::sample_t volt_max_next, volt_min_next, temp_max_next, temp_min_next;
  logic             volt_batch_open_next, temp_batch_open_next;
  logic [1:0]       high_volt_count_next, low_volt_count_next, high_temp_count_next;
  logic             high_volt_latched_next;
  logic [cfm_pkg::FAULT_W-1:0] fault_flags_next;
  logic [cfm_pkg::WARN_W-1:0]  warning_flags_next;
  logic             fault_line_next;

  logic             res_valid;
  cfm_pkg::result_t res;

  logic             is_volt;
  logic             cur_open;
  cfm_pkg::sample_t cur_max, cur_min, new_max, new_min, new_spread;
  logic             hv_release, lv_release, ht_release;
  logic             emit;

  // A non-final sample produces no result, so it may pass a stalled output.
  assign advance = item.valid && (!item.last || !res_valid || results.ready);
  assign emit    = advance && item.last;

  assign is_volt  = (item.kind == cfm_pkg::KIND_VOLT);
  assign cur_open = is_volt ? volt_batch_open : temp_batch_open;
  assign cur_max  = is_volt ? volt_max : temp_max;
  assign cur_min  = is_volt ? volt_min : temp_min;
  assign new_max  = (!cur_open || (item.value > cur_max)) ? item.value : cur_max;
  assign new_min  = (!cur_open || (item.value < cur_min)) ? item.value : cur_min;
  assign new_spread = new_max - new_min;

  // Release bounds in 17 bits: value + margin < fault means value < fault - margin.
  assign hv_release = ({1'b0, new_max} + {1'b0, cfm_pkg::HIGH_VOLT_MARGIN})
                      < {1'b0, thr.high_volt_fault};
  assign lv_release = {1'b0, new_min}
                      > ({1'b0, thr.low_volt_fault} + {1'b0, cfm_pkg::LOW_VOLT_MARGIN});
  assign ht_release = ({1'b0, new_max} + {1'b0, cfm_pkg::HIGH_TEMP_MARGIN})
                      < {1'b0, thr.high_temp_fault};

  always_comb begin
    volt_max_next          = volt_max;
    volt_min_next          = volt_min;
    temp_max_next          = temp_max;
    temp_min_next          = temp_min;
    volt_batch_open_next   = volt_batch_open;
    temp_batch_open_next   = temp_batch_open;
    high_volt_count_next   = high_volt_count;
    low_volt_count_next    = low_volt_count;
    high_temp_count_next   = high_temp_count;
    high_volt_latched_next = high_volt_latched;
    fault_flags_next       = fault_flags;
    warning_flags_next     = warning_flags;
    fault_line_next        = fault_line;

    if (advance) begin
      if (is_volt) begin
        volt_max_next        = new_max;
        volt_min_next        = new_min;
        volt_batch_open_next = !item.last;
      end else begin
        temp_max_next        = new_max;
        temp_min_next        = new_min;
        temp_batch_open_next = !item.last;
      end
    end

    // Actions run in order; the fault line keeps the level of the last one.
    if (emit) begin
      if (is_volt) begin
        if (new_max >= thr.high_volt_warn) begin
          warning_flags_next[cfm_pkg::WARN_HV] = 1'b1;
        end
        if (new_max >= thr.high_volt_fault) begin
          if (high_volt_count > cfm_pkg::DEBOUNCE_LIMIT) begin
            high_volt_latched_next                = 1'b1;
            warning_flags_next[cfm_pkg::WARN_HV]  = 1'b0;
            fault_flags_next[cfm_pkg::FAULT_HV]   = 1'b1;
            fault_line_next                       = 1'b1;
          end else begin
            high_volt_count_next = high_volt_count + 2'd1;
          end
        end else if (hv_release && high_volt_latched && (high_volt_count != 2'd0)) begin
          high_volt_count_next                  = 2'd0;
          high_volt_latched_next                = 1'b0;
          warning_flags_next[cfm_pkg::WARN_HV]  = 1'b0;
          fault_flags_next[cfm_pkg::FAULT_HV]   = 1'b0;
          fault_line_next                       = 1'b0;
        end

        if (new_min <= thr.low_volt_warn) begin
          warning_flags_next[cfm_pkg::WARN_LV] = 1'b1;
        end
        if (new_min <= thr.low_volt_fault) begin
          if (low_volt_count > cfm_pkg::DEBOUNCE_LIMIT) begin
            warning_flags_next[cfm_pkg::WARN_LV] = 1'b0;
            fault_flags_next[cfm_pkg::FAULT_LV]  = 1'b1;
            fault_line_next                      = 1'b1;
          end else begin
            low_volt_count_next = low_volt_count + 2'd1;
          end
        end else if (lv_release && (low_volt_count != 2'd0)) begin
          low_volt_count_next                  = 2'd0;
          warning_flags_next[cfm_pkg::WARN_LV] = 1'b0;
          fault_flags_next[cfm_pkg::FAULT_LV]  = 1'b0;
          fault_line_next                      = 1'b0;
        end

        if (new_spread >= thr.imbalance_warn) begin
          warning_flags_next[cfm_pkg::WARN_IMB] = 1'b1;
        end
      end else begin
        if ((new_max >= thr.high_temp_warn) && (new_max < thr.high_temp_fault)) begin
          warning_flags_next[cfm_pkg::WARN_HT] = 1'b1;
        end
        if (new_max >= thr.high_temp_fault) begin
          if (high_temp_count > cfm_pkg::DEBOUNCE_LIMIT) begin
            warning_flags_next[cfm_pkg::WARN_HT] = 1'b0;
            fault_flags_next[cfm_pkg::FAULT_HT]  = 1'b1;
            fault_line_next                      = 1'b1;
          end else begin
            high_temp_count_next = high_temp_count + 2'd1;
          end
        end else if (ht_release && (high_temp_count != 2'd0)) begin
          high_temp_count_next                 = 2'd0;
          warning_flags_next[cfm_pkg::WARN_HT] = 1'b0;
          fault_flags_next[cfm_pkg::FAULT_HT]  = 1'b0;
          fault_line_next                      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_max          <= '0;
      volt_min          <= '0;
      temp_max          <= '0;
      temp_min          <= '0;
      volt_batch_open   <= 1'b0;
      temp_batch_open   <= 1'b0;
      high_volt_count   <= 2'd0;
      low_volt_count    <= 2'd0;
      high_temp_count   <= 2'd0;
      high_volt_latched <= 1'b0;
      fault_flags       <= '0;
      warning_flags     <= '0;
      fault_line        <= 1'b0;
    end else begin
      volt_max          <= volt_max_next;
      volt_min          <= volt_min_next;
      temp_max          <= temp_max_next;
      temp_min          <= temp_min_next;
      volt_batch_open   <= volt_batch_open_next;
      temp_batch_open   <= temp_batch_open_next;
      high_volt_count   <= high_volt_count_next;
      low_volt_count    <= low_volt_count_next;
      high_temp_count   <= high_temp_count_next;
      high_volt_latched <= high_volt_latched_next;
      fault_flags       <= fault_flags_next;
      warning_flags     <= warning_flags_next;
      fault_line        <= fault_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.kind          <= item.kind;
      res.highest       <= new_max;
      res.lowest        <= new_min;
      res.spread        <= is_volt ? new_spread : cfm_pkg::SAMPLE_MIN;
      res.fault_flags   <= fault_flags_next;
      res.warning_flags <= warning_flags_next;
      res.fault_line    <= fault_line_next;
    end
  end

  assign results.valid             = res_valid;
  assign results.channel_kind      = res.kind;
  assign results.highest           = res.highest;
  assign results.lowest            = res.lowest;
  assign results.spread            = res.spread;
  assign results.fault_flags_out   = res.fault_flags;
  assign results.warning_flags_out = res.warning_flags;
  assign results.fault_line_out    = res.fault_line;

endmodule

### rtl/cell_fault_monitor_core.sv
// A batch result is registered once its last sample has left the input
// register. Throughput: one sample per cycle while results are taken; the
// input and result registers let a new sample in while a result waits.
// Reset (synchronous, active high) restores the threshold defaults and
// clears batch state, debounce counters, flags and the fault line.
`include "cell_fault_monitor_core_defines.svh"

module cell_fault_monitor_core (
  input  logic         clk,
  input  logic         rst,
  cfm_sample_if.sink   samples,
  cfm_result_if.source results,
  cfm_cfg_if.sink      cfg
);

  cfm_pkg::thresholds_t thr;
  cfm_pkg::stage_item_t item;
  logic                 advance;

  cfm_cfg_regs u_cfg_regs (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .thr (thr)
  );

  cfm_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .advance (advance),
    .item    (item)
  );

  cfm_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .thr     (thr),
    .item    (item),
    .advance (advance),
    .results (results)
  );

  // A final sample must not overwrite a result that is still waiting.
  `CFM_ASSERT_NOW(a_no_result_overrun, clk, rst,
    item.valid && item.last && results.valid && !results.ready, !advance,
    "final sample advanced over a pending result")

  // Every final sample that is consumed shows up as a result transaction.
  `CFM_ASSERT_NEXT(a_result_follows_last, clk, rst,
    advance && item.last, results.valid,
    "final sample did not produce a result")

  // The batch maximum never falls below the batch minimum.
  `CFM_ASSERT_NOW(a_max_not_below_min, clk, rst,
    results.valid, results.highest >= results.lowest,
    "result maximum below minimum")

  // The shutdown line is only raised together with a fault bit.
  `CFM_ASSERT_NOW(a_line_has_fault, clk, rst,
    results.valid && results.fault_line_out, results.fault_flags_out != '0,
    "fault line high with no fault flag")

endmodule

### sim/cell_fault_monitor_core_test.sv
module cell_fault_monitor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfm_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PHASES          = 8;
  localparam int PHASE_SAMPLES   = 200;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam longint TIMEOUT_NS  = 4_000_000;

  // Index past the register map; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam int IDLE_PLAN  [4] = '{0, 66, 0, 27};
  localparam int STALL_PLAN [4] = '{0, 0, 66, 27};

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_CONFIG} row_op_t;
  typedef enum int {COND_CALM, COND_OVER, COND_UNDER, COND_NEAR, COND_WILD} condition_t;

  typedef struct packed {
    row_op_t                op;
    kind_t                  kind;
    sample_t                value;
    logic                   is_last;
    logic [CFG_IDX_W-1:0]   idx;
    result_t                typed;
  } dir_row_t;

  typedef struct {
    sample_t              v_max, v_min, t_max, t_min;
    logic                 v_open, t_open;
    logic [1:0]           hv_cnt, lv_cnt, ht_cnt;
    logic                 hv_latched;
    logic [FAULT_W-1:0]   faults;
    logic [WARN_W-1:0]    warns;
    logic                 line;
  } monitor_state_t;

  localparam result_t NO_RESULT = '0;
  localparam int DIR_ROWS = 32;

  // Rows with ROW_CHECKED carry their expected report; ROW_SAMPLE rows use the predictor.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_CHECKED, KIND_VOLT, 16'h0000, 1'b1, '0,
      '{KIND_VOLT, 16'h0000, 16'h0000, 16'h0000, 3'b000, 4'b0010, 1'b0}},
    '{ROW_CHECKED, KIND_TEMP, 16'hFFFF, 1'b1, '0,
      '{KIND_TEMP, 16'hFFFF, 16'hFFFF, 16'h0000, 3'b000, 4'b0010, 1'b0}},
    '{ROW_SAMPLE,  KIND_VOLT, 16'hFFFF, 1'b0, '0, NO_RESULT},
    '{ROW_CHECKED, KIND_VOLT, 16'h0000, 1'b1, '0,
      '{KIND_VOLT, 16'hFFFF, 16'h0000, 16'hFFFF, 3'b000, 4'b0111, 1'b0}},
    '{ROW_SAMPLE,  KIND_VOLT, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'd1000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_TEMP, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'd300,  1'b0, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_TEMP, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'd40000, 1'b0, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_TEMP, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'd200,  1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_TEMP, 16'h0000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'h0000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'h0000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'h0000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'h0000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'hFFFF, 1'b1, '0, NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'd100,   1'b0, REG_HIGH_VOLT_FAULT, NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'd65400, 1'b0, REG_LOW_VOLT_FAULT,  NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'd200,   1'b0, REG_HIGH_TEMP_FAULT, NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'd0,     1'b0, REG_HIGH_TEMP_WARN,  NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'd0,     1'b0, REG_IMBALANCE_WARN,  NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'd0,     1'b0, REG_HIGH_VOLT_WARN,  NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'hFFFF,  1'b0, REG_LOW_VOLT_WARN,   NO_RESULT},
    '{ROW_CONFIG,  KIND_VOLT, 16'h5A5A,  1'b0, CFG_IDX_SPARE,       NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'h0000, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_VOLT, 16'd65500, 1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_TEMP, 16'd300,  1'b1, '0, NO_RESULT},
    '{ROW_SAMPLE,  KIND_TEMP, 16'd10,   1'b1, '0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst;

  cfm_sample_if samples_bus ();
  cfm_result_if results_bus ();
  cfm_cfg_if    cfg_bus ();

  cell_fault_monitor_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_bus),
    .results (results_bus),
    .cfg     (cfg_bus)
  );

  thresholds_t    thr;
  monitor_state_t mon;
  result_t        pending_reports [$];

  int failures;
  int samples_sent;
  int results_checked;
  int settings_used;
  int fault_hits [FAULT_W];
  int releases;
  int sender_idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  condition_t cond_of [2];
  int cond_left [2];

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Folds one sample into the batch state; on a last sample it judges the batch
  // and returns the report that the block should emit.
  function automatic bit evaluate_sample(input kind_t k, input sample_t v, input bit is_last,
                                         output result_t r);
    r = '0;
    if (k == KIND_VOLT) begin
      if (!mon.v_open) begin
        mon.v_max = v;
        mon.v_min = v;
      end else begin
        if (v > mon.v_max) mon.v_max = v;
        if (v < mon.v_min) mon.v_min = v;
      end
      mon.v_open = !is_last;
      if (!is_last) return 1'b0;

      if (mon.v_max >= thr.high_volt_warn) mon.warns[WARN_HV] = 1'b1;
      if (mon.v_max >= thr.high_volt_fault) begin
        if (mon.hv_cnt > DEBOUNCE_LIMIT) begin
          mon.hv_latched       = 1'b1;
          mon.warns[WARN_HV]   = 1'b0;
          mon.faults[FAULT_HV] = 1'b1;
          mon.line             = 1'b1;
          fault_hits[FAULT_HV]++;
        end else begin
          mon.hv_cnt++;
        end
      end else if (mon.hv_latched &&
                   int'(mon.v_max) < int'(thr.high_volt_fault) - int'(HIGH_VOLT_MARGIN)) begin
        if (mon.hv_cnt != 0) begin
          mon.hv_cnt           = '0;
          mon.hv_latched       = 1'b0;
          mon.warns[WARN_HV]   = 1'b0;
          mon.faults[FAULT_HV] = 1'b0;
          mon.line             = 1'b0;
          releases++;
        end
      end

      if (mon.v_min <= thr.low_volt_warn) mon.warns[WARN_LV] = 1'b1;
      if (mon.v_min <= thr.low_volt_fault) begin
        if (mon.lv_cnt > DEBOUNCE_LIMIT) begin
          mon.warns[WARN_LV]   = 1'b0;
          mon.faults[FAULT_LV] = 1'b1;
          mon.line             = 1'b1;
          fault_hits[FAULT_LV]++;
        end else begin
          mon.lv_cnt++;
        end
      end else if (int'(mon.v_min) > int'(thr.low_volt_fault) + int'(LOW_VOLT_MARGIN)) begin
        // No latch on this path: any nonzero count releases.
        if (mon.lv_cnt != 0) begin
          mon.lv_cnt           = '0;
          mon.warns[WARN_LV]   = 1'b0;
          mon.faults[FAULT_LV] = 1'b0;
          mon.line             = 1'b0;
          releases++;
        end
      end

      if (sample_t'(mon.v_max - mon.v_min) >= thr.imbalance_warn) mon.warns[WARN_IMB] = 1'b1;
      r.highest = mon.v_max;
      r.lowest  = mon.v_min;
      r.spread  = mon.v_max - mon.v_min;
    end else begin
      if (!mon.t_open) begin
        mon.t_max = v;
        mon.t_min = v;
      end else begin
        if (v > mon.t_max) mon.t_max = v;
        if (v < mon.t_min) mon.t_min = v;
      end
      mon.t_open = !is_last;
      if (!is_last) return 1'b0;

      if (mon.t_max >= thr.high_temp_warn && mon.t_max < thr.high_temp_fault)
        mon.warns[WARN_HT] = 1'b1;
      if (mon.t_max >= thr.high_temp_fault) begin
        if (mon.ht_cnt > DEBOUNCE_LIMIT) begin
          mon.warns[WARN_HT]   = 1'b0;
          mon.faults[FAULT_HT] = 1'b1;
          mon.line             = 1'b1;
          fault_hits[FAULT_HT]++;
        end else begin
          mon.ht_cnt++;
        end
      end else if (int'(mon.t_max) < int'(thr.high_temp_fault) - int'(HIGH_TEMP_MARGIN)) begin
        if (mon.ht_cnt != 0) begin
          mon.ht_cnt           = '0;
          mon.warns[WARN_HT]   = 1'b0;
          mon.faults[FAULT_HT] = 1'b0;
          mon.line             = 1'b0;
          releases++;
        end
      end

      r.highest = mon.t_max;
      r.lowest  = mon.t_min;
      r.spread  = '0;
    end
    r.kind          = k;
    r.fault_flags   = mon.faults;
    r.warning_flags = mon.warns;
    r.fault_line    = mon.line;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic sample_t extreme_value();
    case ($urandom_range(3))
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return sample_t'($urandom_range(499));
      default: return sample_t'($urandom_range(65535, 65036));
    endcase
  endfunction

  function automatic sample_t pick_value(kind_t k, condition_t c, bit spike);
    int hi_f;
    int lo_f;
    int t;
    hi_f = (k == KIND_VOLT) ? int'(thr.high_volt_fault) : int'(thr.high_temp_fault);
    lo_f = (k == KIND_VOLT) ? int'(thr.low_volt_fault) : 0;
    if (c == COND_WILD) begin
      case ($urandom_range(2))
        0:       return SAMPLE_MIN;
        1:       return SAMPLE_MAX;
        default: return sample_t'($urandom());
      endcase
    end
    if (spike) begin
      case (c)
        COND_OVER:  return sample_t'($urandom_range(65535, hi_f));
        COND_UNDER: return sample_t'($urandom_range(lo_f, 0));
        COND_NEAR: begin
          case ($urandom_range(3))
            0:       t = hi_f;
            1:       t = lo_f;
            2:       t = (k == KIND_VOLT) ? int'(thr.high_volt_warn) : int'(thr.high_temp_warn);
            default: t = (k == KIND_VOLT) ? int'(thr.low_volt_warn)
                                          : hi_f - int'(HIGH_TEMP_MARGIN);
          endcase
          t = t + int'($urandom_range(1400)) - 700;
          if (t < 0) t = 0;
          if (t > 65535) t = 65535;
          return sample_t'(t);
        end
        default: ;
      endcase
    end
    // Calm band: clear of both fault thresholds by more than the release margins.
    lo_f = lo_f + int'(LOW_VOLT_MARGIN) + 1;
    hi_f = hi_f - int'(HIGH_VOLT_MARGIN) - 1;
    if (lo_f > hi_f) return sample_t'($urandom());
    return sample_t'($urandom_range(hi_f, lo_f));
  endfunction

  // Leaves valid high on return so back-to-back transactions need no extra edge.
  task automatic send_sample(kind_t k, sample_t v, bit is_last, bit use_typed, result_t typed);
    result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      samples_bus.valid <= 1'b0;
      @(negedge clk);
    end
    samples_bus.valid        <= 1'b1;
    samples_bus.cmd          <= k;
    samples_bus.sample_value <= v;
    samples_bus.last_sample  <= is_last;
    do @(posedge clk); while (!samples_bus.ready);
    if (evaluate_sample(k, v, is_last, r)) pending_reports.push_back(use_typed ? typed : r);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    samples_bus.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    // Samples without a report may still sit in the pipeline.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, sample_t data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_HIGH_VOLT_WARN:  thr.high_volt_warn  = data;
      REG_HIGH_VOLT_FAULT: thr.high_volt_fault = data;
      REG_LOW_VOLT_WARN:   thr.low_volt_warn   = data;
      REG_LOW_VOLT_FAULT:  thr.low_volt_fault  = data;
      REG_IMBALANCE_WARN:  thr.imbalance_warn  = data;
      REG_HIGH_TEMP_WARN:  thr.high_temp_warn  = data;
      REG_HIGH_TEMP_FAULT: thr.high_temp_fault = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(int style);
    thresholds_t t;
    case (style)
      0: begin
        t.high_volt_fault = sample_t'($urandom_range(64000, 40000));
        t.high_volt_warn  = t.high_volt_fault - sample_t'($urandom_range(3000));
        t.low_volt_fault  = sample_t'($urandom_range(20000, 500));
        t.low_volt_warn   = t.low_volt_fault + sample_t'($urandom_range(3000));
        t.imbalance_warn  = sample_t'($urandom_range(20000));
        t.high_temp_fault = sample_t'($urandom_range(60000, 2000));
        t.high_temp_warn  = t.high_temp_fault - sample_t'($urandom_range(2000));
      end
      1: t = thresholds_t'({$urandom(), $urandom(), $urandom(), $urandom()});
      default: begin
        t.high_volt_warn  = extreme_value();
        t.high_volt_fault = extreme_value();
        t.low_volt_warn   = extreme_value();
        t.low_volt_fault  = extreme_value();
        t.imbalance_warn  = extreme_value();
        t.high_temp_warn  = extreme_value();
        t.high_temp_fault = extreme_value();
      end
    endcase
    write_reg(REG_HIGH_VOLT_WARN,  t.high_volt_warn);
    write_reg(REG_HIGH_VOLT_FAULT, t.high_volt_fault);
    write_reg(REG_LOW_VOLT_WARN,   t.low_volt_warn);
    write_reg(REG_LOW_VOLT_FAULT,  t.low_volt_fault);
    write_reg(REG_IMBALANCE_WARN,  t.imbalance_warn);
    write_reg(REG_HIGH_TEMP_WARN,  t.high_temp_warn);
    write_reg(REG_HIGH_TEMP_FAULT, t.high_temp_fault);
    if ($urandom_range(1)) write_reg(CFG_IDX_SPARE, sample_t'($urandom()));
    settings_used++;
  endtask

  // One batch of a kind under that kind's current condition, which holds for a few
  // batches so the debounce counters can run out; stray samples of the other kind
  // are mixed in now and then.
  task automatic send_batch();
    kind_t k;
    kind_t other;
    int n;
    int spike;
    int r;
    k = kind_t'($urandom_range(1));
    other = (k == KIND_VOLT) ? KIND_TEMP : KIND_VOLT;
    if (cond_left[k] == 0) begin
      r = $urandom_range(99);
      cond_of[k] = (r < 30) ? COND_CALM : (r < 55) ? COND_OVER : (r < 75) ? COND_UNDER :
                   (r < 90) ? COND_NEAR : COND_WILD;
      cond_left[k] = $urandom_range(7, 2);
    end
    cond_left[k]--;
    n = ($urandom_range(15) == 0) ? $urandom_range(16, 6) : $urandom_range(5, 1);
    spike = $urandom_range(n - 1);
    for (r = 0; r < n; r++) begin
      if ($urandom_range(9) == 0)
        send_sample(other, pick_value(other, COND_WILD, 1'b0), $urandom_range(3) == 0,
                    1'b0, NO_RESULT);
      send_sample(k, pick_value(k, cond_of[k], r == spike), r == n - 1, 1'b0, NO_RESULT);
    end
  endtask

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      results_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      results_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : report_check
    result_t want;
    if (!rst && results_bus.valid && results_bus.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report with nothing pending: kind %0d highest 0x%0h lowest 0x%0h",
               results_bus.channel_kind, results_bus.highest, results_bus.lowest);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("channel_kind",      want.kind,          results_bus.channel_kind);
        check_field("highest",           want.highest,       results_bus.highest);
        check_field("lowest",            want.lowest,        results_bus.lowest);
        check_field("spread",            want.spread,        results_bus.spread);
        check_field("fault_flags_out",   want.fault_flags,   results_bus.fault_flags_out);
        check_field("warning_flags_out", want.warning_flags, results_bus.warning_flags_out);
        check_field("fault_line_out",    want.fault_line,    results_bus.fault_line_out);
        results_checked++;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d reports still pending.", pending_reports.size());
    $display("cell_fault_monitor_core test failed");
    $finish;
  end

  initial begin
    int p;
    int phase_start;
    bit mid_done;
    dir_row_t row;

    rst = 1'b1;
    samples_bus.valid        = 1'b0;
    samples_bus.cmd          = KIND_VOLT;
    samples_bus.sample_value = '0;
    samples_bus.last_sample  = 1'b0;
    cfg_bus.valid            = 1'b0;
    cfg_bus.index            = '0;
    cfg_bus.data             = '0;
    failures        = 0;
    samples_sent    = 0;
    results_checked = 0;
    settings_used   = 1;
    releases        = 0;
    fault_hits      = '{default: 0};
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_req        = 0;
    hold_left       = 0;
    cond_left       = '{default: 0};
    cond_of         = '{default: COND_CALM};
    mon = '{default: '0};
    thr.high_volt_warn  = SAMPLE_MAX;
    thr.high_volt_fault = SAMPLE_MAX;
    thr.low_volt_warn   = SAMPLE_MIN;
    thr.low_volt_fault  = SAMPLE_MIN;
    thr.imbalance_warn  = SAMPLE_MAX;
    thr.high_temp_warn  = SAMPLE_MAX;
    thr.high_temp_fault = SAMPLE_MAX;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: walks the debounce, latch and release paths at the reset
    // thresholds, then moves the thresholds so the fault margins leave range.
    for (p = 0; p < DIR_ROWS; p++) begin
      row = DIRECTED[p];
      if (row.op == ROW_CONFIG) begin
        wait_drained();
        write_reg(row.idx, row.value);
      end else begin
        send_sample(row.kind, row.value, row.is_last, row.op == ROW_CHECKED, row.typed);
      end
    end
    settings_used++;

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      sender_idle_pct = IDLE_PLAN[p % 4];
      stall_pct       = STALL_PLAN[p % 4];
      set_thresholds(p % 3);
      // Long receiver stall while samples keep coming, so the block backs up.
      if (p % 4 == 0) hold_req = HOLD_OFF_CYCLES;
      phase_start = samples_sent;
      mid_done = 1'b0;
      while (samples_sent - phase_start < PHASE_SAMPLES) begin
        send_batch();
        if (!mid_done && samples_sent - phase_start >= PHASE_SAMPLES / 2) begin
          wait_drained();
          mid_done = 1'b1;
        end
      end
    end
    wait_drained();

    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      failures++;
    end
    $display("Checked %0d batch reports from %0d samples under %0d threshold settings.",
             results_checked, samples_sent, settings_used);
    $display("Fault-level judgements: high volt %0d, low volt %0d, high temp %0d; releases %0d.",
             fault_hits[FAULT_HV], fault_hits[FAULT_LV], fault_hits[FAULT_HT], releases);
    if (failures == 0) begin
      $display("cell_fault_monitor_core test passed");
    end else begin
      $display("cell_fault_monitor_core test failed");
    end
    $finish;
  end

endmodule

### cell_fault_monitor_core.f
+incdir+rtl
rtl/cfm_pkg.sv
rtl/cfm_sample_if.sv
rtl/cfm_result_if.sv
rtl/cfm_cfg_if.sv
rtl/cfm_cfg_regs.sv
rtl/cfm_in_stage.sv
rtl/cfm_eval.sv
rtl/cell_fault_monitor_core.sv
sim/cell_fault_monitor_core_test.sv
